/* rtl/mrf_pkg.sv */
// Shared types, codes and helpers for the Modbus RTU request framer.
// No dependencies; imported by every module of the block.
package mrf_pkg;

  localparam logic [7:0] FcReadHolding  = 8'd3;
  localparam logic [7:0] FcWriteSingle  = 8'd6;
  localparam logic [7:0] FcWriteMulti   = 8'd16;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam int unsigned QDepth = 2;

  // index of the last body byte (before the CRC)
  localparam logic [3:0] BodyLastShort = 4'd5;
  localparam logic [3:0] BodyLastLong  = 4'd10;

  typedef enum logic [1:0] {
    KIND_READ    = 2'd0,
    KIND_WSINGLE = 2'd1,
    KIND_WMULTI  = 2'd2,
    KIND_INVALID = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  func;
    logic [7:0]  addr;
    logic [15:0] start;
    logic [15:0] second;
    logic [7:0]  bcount;
    logic [31:0] word;
  } req_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] byte_sel(input req_t r, input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = r.addr;
      4'd1:    b = r.func;
      4'd2:    b = r.start[15:8];
      4'd3:    b = r.start[7:0];
      4'd4:    b = r.second[15:8];
      4'd5:    b = r.second[7:0];
      4'd6:    b = r.bcount;
      4'd7:    b = r.word[31:24];
      4'd8:    b = r.word[23:16];
      4'd9:    b = r.word[15:8];
      4'd10:   b = r.word[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* rtl/mrf_front.sv */
// Request intake: decodes the function code and builds the queued request record.
// Depends on mrf_pkg.
module mrf_front import mrf_pkg::*; (
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // addr, start, count, value, bcount, word
  input  logic [7:0]  s_axis_tuser,  // function code
  input  logic        full_i,
  output logic        push_o,
  output req_t        entry_o
);

  kind_e kind;

  always_comb begin
    unique case (s_axis_tuser)
      FcReadHolding: kind = KIND_READ;
      FcWriteSingle: kind = KIND_WSINGLE;
      FcWriteMulti:  kind = KIND_WMULTI;
      default:       kind = KIND_INVALID;
    endcase
  end

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  always_comb begin
    entry_o.kind   = kind;
    entry_o.func   = s_axis_tuser;
    entry_o.addr   = s_axis_tdata[7:0];
    entry_o.start  = s_axis_tdata[23:8];
    entry_o.second = (kind == KIND_WSINGLE) ? s_axis_tdata[55:40] : s_axis_tdata[39:24];
    entry_o.bcount = s_axis_tdata[63:56];
    entry_o.word   = s_axis_tdata[95:64];
  end

endmodule

/* rtl/mrf_fifo.sv */
// Two-entry request queue between intake and frame sequencer.
// Depends on mrf_pkg.
module mrf_fifo import mrf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t entry_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output req_t head_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  req_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

/* rtl/mrf_back.sv */
// Frame sequencer: emits one frame byte per transaction with a running CRC-16.
// Depends on mrf_pkg; fed from mrf_fifo.
module mrf_back import mrf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  req_t       head_i,
  output logic       pop_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // frame byte
  output logic       m_axis_tlast,
  output logic       m_axis_tuser   // invalid code flag
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_BODY   = 4'b0010,
    ST_CRC_LO = 4'b0100,
    ST_CRC_HI = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  req_t        req_q, req_d;
  logic [3:0]  idx_q, idx_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q;
  logic [7:0]  out_data_q;
  logic        out_last_q, out_user_q;

  logic        can_load, load;
  logic [7:0]  ld_data, cur_byte;
  logic        ld_last, ld_user;
  logic [3:0]  last_idx;

  assign can_load = !out_valid_q || m_axis_tready;
  assign cur_byte = byte_sel(req_q, idx_q);
  assign last_idx = (req_q.kind == KIND_WMULTI) ? BodyLastLong : BodyLastShort;

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    idx_d   = idx_q;
    crc_d   = crc_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    ld_data = 8'h00;
    ld_last = 1'b0;
    ld_user = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i && can_load) begin
          pop_o = 1'b1;
          load  = 1'b1;
          req_d = head_i;
          if (head_i.kind == KIND_INVALID) begin
            ld_user = 1'b1;
          end else begin
            ld_data = head_i.addr;
            crc_d   = crc_byte(CrcInit, head_i.addr);
            idx_d   = 4'd1;
            state_d = ST_BODY;
          end
        end
      end
      ST_BODY: begin
        if (can_load) begin
          load    = 1'b1;
          ld_data = cur_byte;
          crc_d   = crc_byte(crc_q, cur_byte);
          idx_d   = idx_q + 4'd1;
          if (idx_q == last_idx) begin
            state_d = ST_CRC_LO;
          end
        end
      end
      ST_CRC_LO: begin
        if (can_load) begin
          load    = 1'b1;
          ld_data = crc_q[7:0];
          state_d = ST_CRC_HI;
        end
      end
      ST_CRC_HI: begin
        if (can_load) begin
          load    = 1'b1;
          ld_data = crc_q[15:8];
          ld_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    idx_q <= idx_d;
    crc_q <= crc_d;
    if (load) begin
      out_data_q <= ld_data;
      out_last_q <= ld_last;
      out_user_q <= ld_user;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

endmodule

/* rtl/modbus_rtu_request_framer.sv */
// Modbus RTU request framer, top level.
// Depends on mrf_pkg, mrf_front, mrf_fifo and mrf_back.
//
// Each accepted request becomes one frame on the output stream, one byte per
// transaction: 8 bytes for read holding (3) and write single (6), 13 bytes for
// write multiple (16), CRC-16 low byte then high byte at the end, tlast on the
// final byte. Any other function code gives a single transaction with tuser
// set and data/tlast zero. The byte sequencer emits one byte per cycle while
// m_axis_tready does not stall the output, with a running byte-wide CRC; a
// two-entry queue keeps accepting requests while a frame drains.
module modbus_rtu_request_framer import mrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] device_address, [23:8] start_register, [39:24] register_count,
  // [55:40] write_value, [63:56] payload_byte_count, [95:64] payload_word
  input  logic [95:0] s_axis_tdata,
  input  logic [7:0]  s_axis_tuser,   // [7:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
  output logic        m_axis_tlast,   // last_byte
  output logic        m_axis_tuser    // [0] invalid_code
);

  req_t entry, head;
  logic push, pop, full, head_valid;

  mrf_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (entry)
  );

  mrf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  mrf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* tb/sv/tb_modbus_rtu_request_framer.sv */
// Self-checking testbench for modbus_rtu_request_framer: drives requests on the input stream,
// builds the expected frame bytes and CRC-16 independently, and checks every output transaction.
// Depends on mrf_pkg and the framer RTL.
module tb_modbus_rtu_request_framer;
  import mrf_pkg::*;

  localparam int NumRandom = 190;
  localparam int IdleLimit = 2000;
  localparam int TailCycles = 40;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic [7:0]  op;
    logic [7:0]  addr;
    logic [15:0] start;
    logic [15:0] count;
    logic [15:0] value;
    logic [7:0]  bcount;
    logic [31:0] word;
  } mb_request_t;

  typedef struct {
    mb_request_t req;
    bit          drain_first;
  } pending_request_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad_code;
  } frame_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [7:0] device_address, [23:8] start_register, [39:24] register_count,
  // [55:40] write_value, [63:56] payload_byte_count, [95:64] payload_word
  logic [95:0] s_axis_tdata = '0;
  logic [7:0]  s_axis_tuser = '0;  // [7:0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // [7:0] frame_byte
  logic        m_axis_tlast;
  logic        m_axis_tuser;       // [0] invalid_code

  pending_request_t request_q[$];
  frame_beat_t      frame_byte_q[$];

  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  bit src_burst = 1'b0;
  bit sink_burst = 1'b0;
  int src_gap = 0;
  int sink_stall = 0;
  int sent_cnt = 0;
  int checked_cnt = 0;
  int mismatch_cnt = 0;
  int idle_cycles = 0;
  int n_read = 0;
  int n_single = 0;
  int n_multi = 0;
  int n_bad = 0;

  modbus_rtu_request_framer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // bitwise reflected CRC, one data bit at a time
  function automatic logic [15:0] modbus_crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) c = c ^ CrcPoly;
    end
    return c;
  endfunction

  function automatic void predict_frame(input mb_request_t r);
    logic [7:0]  bytes[$];
    logic [15:0] crc;
    logic [15:0] second;
    frame_beat_t beat;
    if (r.op != FcReadHolding && r.op != FcWriteSingle && r.op != FcWriteMulti) begin
      beat.data = 8'h00;
      beat.last = 1'b0;
      beat.bad_code = 1'b1;
      frame_byte_q = {frame_byte_q, beat};
      n_bad++;
      return;
    end
    second = (r.op == FcWriteSingle) ? r.value : r.count;
    bytes = '{r.addr, r.op, r.start[15:8], r.start[7:0], second[15:8], second[7:0]};
    if (r.op == FcWriteMulti) begin
      bytes = {bytes, r.bcount, r.word[31:24], r.word[23:16], r.word[15:8], r.word[7:0]};
      n_multi++;
    end else if (r.op == FcWriteSingle) begin
      n_single++;
    end else begin
      n_read++;
    end
    crc = CrcInit;
    foreach (bytes[i]) crc = modbus_crc_update(crc, bytes[i]);
    bytes = {bytes, crc[7:0], crc[15:8]};
    foreach (bytes[i]) begin
      beat.data = bytes[i];
      beat.last = (i == bytes.size() - 1);
      beat.bad_code = 1'b0;
      frame_byte_q = {frame_byte_q, beat};
    end
  endfunction

  function automatic mb_request_t mk_req(input logic [7:0] op, input logic [7:0] addr,
                                         input logic [15:0] start, input logic [15:0] count,
                                         input logic [15:0] value, input logic [7:0] bcount,
                                         input logic [31:0] word);
    mb_request_t r;
    r = '{op, addr, start, count, value, bcount, word};
    return r;
  endfunction

  function automatic void queue_req(input mb_request_t r, input bit drain_first);
    pending_request_t p;
    p.req = r;
    p.drain_first = drain_first;
    request_q = {request_q, p};
  endfunction

  // sample handshakes, predict on input, check on output
  always @(posedge clk_i) begin
    frame_beat_t got;
    frame_beat_t want;
    mb_request_t r;
    in_fire <= s_axis_tvalid && s_axis_tready;
    out_fire <= m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        r.op = s_axis_tuser;
        r.addr = s_axis_tdata[7:0];
        r.start = s_axis_tdata[23:8];
        r.count = s_axis_tdata[39:24];
        r.value = s_axis_tdata[55:40];
        r.bcount = s_axis_tdata[63:56];
        r.word = s_axis_tdata[95:64];
        predict_frame(r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata, m_axis_tlast, m_axis_tuser};
        if (frame_byte_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports)
            $display("unexpected output transaction: data=%02h last=%b invalid=%b",
                     got.data, got.last, got.bad_code);
        end else begin
          want = frame_byte_q.pop_front();
          checked_cnt++;
          if (got.data !== want.data || got.last !== want.last ||
              got.bad_code !== want.bad_code) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MaxReports)
              $display("byte %0d: exp data/last/invalid %02h/%b/%b, got %02h/%b/%b",
                       checked_cnt, want.data, want.last, want.bad_code,
                       got.data, got.last, got.bad_code);
          end
        end
      end
    end
  end

  // source: one draw of gap cycles per request, with bursts of back-to-back requests
  always @(negedge clk_i) begin
    pending_request_t nxt;
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (src_gap != 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (request_q.size() != 0 &&
                   (!request_q[0].drain_first || frame_byte_q.size() == 0)) begin
        nxt = request_q.pop_front();
        s_axis_tdata <= {nxt.req.word, nxt.req.bcount, nxt.req.value, nxt.req.count,
                         nxt.req.start, nxt.req.addr};
        s_axis_tuser <= nxt.req.op;
        s_axis_tvalid <= 1'b1;
        src_gap <= src_burst ? 0 : $urandom_range(0, 7);
        sent_cnt <= sent_cnt + 1;
        if (sent_cnt % 20 == 19) src_burst <= ($urandom_range(0, 2) == 0);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // sink: one draw of stall cycles per output transaction
  always @(negedge clk_i) begin
    int d;
    if (rst_ni) begin
      if (out_fire) begin
        d = sink_burst ? 0 : $urandom_range(0, 7);
        sink_stall <= d;
        m_axis_tready <= (d == 0);
        if (checked_cnt % 40 == 39) sink_burst <= ($urandom_range(0, 2) == 0);
      end else if (sink_stall != 0) begin
        sink_stall <= sink_stall - 1;
        m_axis_tready <= (sink_stall == 1);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_fire || out_fire) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
        $display("timeout: no transaction for %0d cycles", IdleLimit);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    mb_request_t r;
    int sel;

    // directed: field extremes, every code, unsupported codes with busy unused fields
    queue_req(mk_req(FcReadHolding, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 32'h0), 1'b0);
    queue_req(mk_req(FcReadHolding, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, '1), 1'b0);
    queue_req(mk_req(FcReadHolding, 8'h01, 16'h0000, 16'h000A, 16'hBEEF, 8'h5A, 32'h1234), 1'b0);
    queue_req(mk_req(FcWriteSingle, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 32'h0), 1'b0);
    queue_req(mk_req(FcWriteSingle, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, '1), 1'b0);
    queue_req(mk_req(FcWriteSingle, 8'h11, 16'h0001, 16'hAAAA, 16'h0003, 8'h33, 32'h5555), 1'b0);
    queue_req(mk_req(FcWriteMulti, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 32'h0), 1'b0);
    queue_req(mk_req(FcWriteMulti, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, '1), 1'b0);
    queue_req(mk_req(FcWriteMulti, 8'h01, 16'h0064, 16'h0002, 16'h1111, 8'h04, 32'h3F800000),
              1'b0);
    queue_req(mk_req(FcWriteMulti, 8'hA5, 16'h5AA5, 16'hA55A, 16'h0000, 8'h80, 32'h80000001),
              1'b0);
    queue_req(mk_req(8'h00, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, '1), 1'b0);
    queue_req(mk_req(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, '1), 1'b0);
    queue_req(mk_req(8'h01, 8'h12, 16'h3456, 16'h789A, 16'hBCDE, 8'hF0, 32'hDEADBEEF), 1'b0);
    queue_req(mk_req(8'h02, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 32'h0), 1'b0);
    queue_req(mk_req(8'h04, 8'h01, 16'h0001, 16'h0001, 16'h0001, 8'h01, 32'h1), 1'b0);
    queue_req(mk_req(8'h05, 8'h55, 16'h5555, 16'h5555, 16'h5555, 8'h55, 32'h55555555), 1'b0);
    queue_req(mk_req(8'h0F, 8'hAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 8'hAA, 32'hAAAAAAAA), 1'b0);
    queue_req(mk_req(8'h13, 8'h01, 16'h0000, 16'h0001, 16'h0000, 8'h02, 32'h0), 1'b0);
    queue_req(mk_req(8'h83, 8'h01, 16'h0000, 16'h0001, 16'h0000, 8'h02, 32'h0), 1'b0);
    queue_req(mk_req(FcReadHolding, 8'hF7, 16'h0000, 16'h007D, 16'h0000, 8'h00, 32'h0), 1'b1);

    for (int i = 0; i < NumRandom; i++) begin
      sel = $urandom_range(0, 9);
      r.op = (sel < 3) ? FcReadHolding :
             (sel < 6) ? FcWriteSingle :
             (sel < 9) ? FcWriteMulti : 8'($urandom_range(0, 255));
      r.addr = 8'($urandom);
      r.start = 16'($urandom);
      r.count = 16'($urandom);
      r.value = 16'($urandom);
      r.bcount = 8'($urandom);
      r.word = $urandom;
      queue_req(r, (i == 70 || i == 150));
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (request_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (frame_byte_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d requests: %0d read holding, %0d write single, %0d write multiple,",
             n_read + n_single + n_multi + n_bad, n_read, n_single, n_multi);
    $display("%0d unsupported codes; %0d output bytes checked, %0d mismatches",
             n_bad, checked_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && frame_byte_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/mrf_pkg.sv
rtl/mrf_front.sv
rtl/mrf_fifo.sv
rtl/mrf_back.sv
rtl/modbus_rtu_request_framer.sv
tb/sv/tb_modbus_rtu_request_framer.sv
